>>> rtl/core/sse_pkg.sv
// Shared types, character codes and field-name tables for the event-stream parser.
package sse_pkg;

    typedef enum logic [3:0] {
        KIND_DATA_BYTE   = 4'd0,
        KIND_EVENT_START = 4'd1,
        KIND_EVENT_BYTE  = 4'd2,
        KIND_ID_START    = 4'd3,
        KIND_ID_BYTE     = 4'd4,
        KIND_ID_ACCEPT   = 4'd5,
        KIND_ID_REJECT   = 4'd6,
        KIND_RETRY_SET   = 4'd7,
        KIND_DISPATCH    = 4'd8,
        KIND_DISCARD     = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        PH_NAME   = 2'd0,
        PH_VALUE  = 2'd1,
        PH_IGNORE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        FLD_DATA  = 2'd0,
        FLD_EVENT = 2'd1,
        FLD_ID    = 2'd2,
        FLD_RETRY = 2'd3
    } field_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] NAME_COUNT_MAX = 3'd7;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  name_count;
        logic [3:0]  cands;
        field_t      field_code;
        logic        value_start;
        logic        cr_held;
        logic [31:0] retry_accum;
        logic        retry_ok;
        logic        retry_digit_seen;
        logic        id_nul_seen;
        logic        data_seen;
        logic [31:0] retry_value;
        logic        retry_valid;
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value_byte;
        logic [31:0] retry_ms;
        logic        retry_known;
        logic        last;
    } result_t;

    // Up to two results produced by one byte, handed to the output buffer.
    typedef struct packed {
        logic        valid;
        logic [1:0]  cnt;
        result_t     r0;
        result_t     r1;
    } push_t;

    function automatic logic [2:0] cand_len(field_t c);
        logic [2:0] len;
        unique case (c)
            FLD_DATA:  len = 3'd4;
            FLD_EVENT: len = 3'd5;
            FLD_ID:    len = 3'd2;
            FLD_RETRY: len = 3'd5;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] cand_char(field_t c, logic [2:0] idx);
        logic [39:0] name;
        unique case (c)
            FLD_DATA:  name = {8'h00, "atad"};
            FLD_EVENT: name = "tneve";
            FLD_ID:    name = {24'h000000, "di"};
            FLD_RETRY: name = "yrter";
            default:   name = '0;
        endcase
        // names stored reversed so that character 0 sits in the low byte
        return (idx < 3'd5) ? name[idx*8 +: 8] : 8'h00;
    endfunction

endpackage

>>> rtl/core/sse_if.sv
// Stream channel interfaces: raw byte input and tagged result output.
interface sse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface sse_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  value_byte;
    logic [31:0] retry_ms;
    logic        retry_known;
    logic        last;

    modport source (output valid, output kind, output value_byte, output retry_ms,
                    output retry_known, output last, input ready);
    modport sink   (input valid, input kind, input value_byte, input retry_ms,
                    input retry_known, input last, output ready);
endinterface

>>> rtl/core/sse_step.sv
// Per-byte parse step: next parser state and up to two results for one byte.
module sse_step (
    input  sse_pkg::state_t state,
    input  logic [7:0]      byte_in,
    output sse_pkg::state_t state_next,
    output sse_pkg::push_t  push
);
    import sse_pkg::*;

    typedef struct packed {
        state_t     st;
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } ctx_t;

    function automatic ctx_t emit(ctx_t x, kind_t k, logic [7:0] vb);
        ctx_t    y;
        result_t r;
        y = x;
        r.kind        = k;
        r.value_byte  = (k == KIND_DATA_BYTE || k == KIND_EVENT_BYTE || k == KIND_ID_BYTE)
                        ? vb : 8'd0;
        r.retry_ms    = (k == KIND_RETRY_SET || k == KIND_DISPATCH)
                        ? x.st.retry_value : 32'd0;
        r.retry_known = x.st.retry_valid;
        r.last        = 1'b0;
        if (x.cnt == 2'd0)
        begin
            y.r0  = r;
            y.cnt = 2'd1;
        end
        else if (x.cnt == 2'd1)
        begin
            y.r1  = r;
            y.cnt = 2'd2;
        end
        return y;
    endfunction

    // {found, code}; the lowest live candidate of matching length wins
    function automatic logic [2:0] match_name(state_t s);
        logic [2:0] m;
        m = 3'b000;
        for (int c = 3; c >= 0; c--)
        begin
            if (s.cands[c] && s.name_count == cand_len(field_t'(c[1:0])))
                m = {1'b1, c[1:0]};
        end
        return m;
    endfunction

    function automatic state_t name_byte(state_t s, logic [7:0] b);
        state_t t;
        t = s;
        for (int c = 0; c < 4; c++)
        begin
            if (s.cands[c] && (s.name_count >= cand_len(field_t'(c[1:0])) ||
                cand_char(field_t'(c[1:0]), s.name_count) != b))
                t.cands[c] = 1'b0;
        end
        if (s.name_count < NAME_COUNT_MAX)
            t.name_count = s.name_count + 3'd1;
        return t;
    endfunction

    function automatic ctx_t open_field(ctx_t x, field_t f);
        ctx_t y;
        y = x;
        y.st.phase      = PH_VALUE;
        y.st.field_code = f;
        unique case (f)
            FLD_DATA:
            begin
                if (x.st.data_seen)
                    y = emit(y, KIND_DATA_BYTE, CH_LF);
                y.st.data_seen = 1'b1;
            end
            FLD_EVENT: y = emit(y, KIND_EVENT_START, 8'd0);
            FLD_ID:    y = emit(y, KIND_ID_START, 8'd0);
            FLD_RETRY: y = y;
            default:   y = y;
        endcase
        return y;
    endfunction

    function automatic ctx_t close_field(ctx_t x);
        ctx_t y;
        y = x;
        if (x.st.field_code == FLD_ID)
        begin
            y = emit(y, x.st.id_nul_seen ? KIND_ID_REJECT : KIND_ID_ACCEPT, 8'd0);
        end
        else if (x.st.field_code == FLD_RETRY && x.st.retry_ok && x.st.retry_digit_seen)
        begin
            y.st.retry_value = x.st.retry_accum;
            y.st.retry_valid = 1'b1;
            y = emit(y, KIND_RETRY_SET, 8'd0);
        end
        return y;
    endfunction

    function automatic state_t clear_line(state_t s);
        state_t t;
        t = s;
        t.phase            = PH_NAME;
        t.name_count       = 3'd0;
        t.cands            = 4'hF;
        t.field_code       = FLD_DATA;
        t.value_start      = 1'b1;
        t.cr_held          = 1'b0;
        t.retry_accum      = 32'd0;
        t.retry_ok         = 1'b1;
        t.retry_digit_seen = 1'b0;
        t.id_nul_seen      = 1'b0;
        return t;
    endfunction

    function automatic ctx_t plain_byte(ctx_t x, logic [7:0] b);
        ctx_t        y;
        logic [2:0]  m;
        logic [35:0] n;
        logic [7:0]  digit;
        y     = x;
        m     = match_name(x.st);
        digit = b - CH_ZERO;
        n     = ({4'd0, x.st.retry_accum} << 3) + ({4'd0, x.st.retry_accum} << 1)
              + {32'd0, digit[3:0]};
        unique case (x.st.phase)
            PH_NAME:
            begin
                if (b == CH_COLON)
                begin
                    if (!m[2])
                        y.st.phase = PH_IGNORE;
                    else
                        y = open_field(y, field_t'(m[1:0]));
                end
                else
                begin
                    y.st = name_byte(x.st, b);
                end
            end
            PH_VALUE:
            begin
                y.st.value_start = 1'b0;
                if (!(x.st.value_start && b == CH_SPACE))
                begin
                    unique case (x.st.field_code)
                        FLD_DATA:  y = emit(y, KIND_DATA_BYTE, b);
                        FLD_EVENT: y = emit(y, KIND_EVENT_BYTE, b);
                        FLD_ID:
                        begin
                            if (b == CH_NUL)
                                y.st.id_nul_seen = 1'b1;
                            y = emit(y, KIND_ID_BYTE, b);
                        end
                        FLD_RETRY:
                        begin
                            if (x.st.retry_ok)
                            begin
                                if (b < CH_ZERO || b > CH_NINE)
                                begin
                                    y.st.retry_ok = 1'b0;
                                end
                                else
                                begin
                                    y.st.retry_digit_seen = 1'b1;
                                    if (n[35:32] != 4'd0)
                                        y.st.retry_ok = 1'b0;
                                    else
                                        y.st.retry_accum = n[31:0];
                                end
                            end
                        end
                        default: y = y;
                    endcase
                end
            end
            default: y = y;
        endcase
        return y;
    endfunction

    function automatic ctx_t finish_line(ctx_t x);
        ctx_t       y;
        logic [2:0] m;
        y = x;
        m = match_name(x.st);
        if (x.st.phase == PH_NAME)
        begin
            if (x.st.name_count == 3'd0)
            begin
                y = emit(y, x.st.data_seen ? KIND_DISPATCH : KIND_DISCARD, 8'd0);
                y.st.data_seen = 1'b0;
            end
            else if (m[2])
            begin
                y = open_field(y, field_t'(m[1:0]));
            end
        end
        if (y.st.phase == PH_VALUE)
            y = close_field(y);
        y.st = clear_line(y.st);
        return y;
    endfunction

    ctx_t x;

    always_comb
    begin
        x.st  = state;
        x.cnt = 2'd0;
        x.r0  = '0;
        x.r1  = '0;
        if (byte_in == CH_LF)
        begin
            x.st.cr_held = 1'b0;
            x = finish_line(x);
        end
        else
        begin
            if (state.cr_held)
            begin
                x.st.cr_held = 1'b0;
                x = plain_byte(x, CH_CR);
            end
            if (byte_in == CH_CR)
                x.st.cr_held = 1'b1;
            else
                x = plain_byte(x, byte_in);
        end
        if (x.cnt == 2'd1)
            x.r0.last = 1'b1;
        if (x.cnt == 2'd2)
            x.r1.last = 1'b1;
    end

    assign state_next = x.st;
    assign push.valid = (x.cnt != 2'd0);
    assign push.cnt   = x.cnt;
    assign push.r0    = x.r0;
    assign push.r1    = x.r1;

endmodule

>>> rtl/core/sse_obuf.sv
// Two-slot result register that plays out one or two results per byte.
module sse_obuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sse_pkg::push_t       push,
    output logic                 free,
    sse_result_if.source         events
);
    import sse_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] rem_reg, rem_next;
    logic       xfer;

    assign xfer = events.valid && events.ready;
    // room for a new pair: empty, or the last pending result leaves this cycle
    assign free = (rem_reg == 2'd0) || (rem_reg == 2'd1 && events.ready);

    always_comb
    begin
        rem_next   = rem_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push.valid)
        begin
            rem_next   = push.cnt;
            slot0_next = push.r0;
            slot1_next = push.r1;
        end
        else if (xfer)
        begin
            rem_next   = rem_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= 2'd0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign events.valid       = (rem_reg != 2'd0);
    assign events.kind        = slot0_reg.kind;
    assign events.value_byte  = slot0_reg.value_byte;
    assign events.retry_ms    = slot0_reg.retry_ms;
    assign events.retry_known = slot0_reg.retry_known;
    assign events.last        = slot0_reg.last;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> free)
        else $error("result pair loaded while results still pending");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && !events.last) |=> events.valid)
        else $error("second result of a byte went missing");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 2'd3)
        else $error("pending result count out of range");

endmodule

>>> rtl/core/sse_stream_parser.sv
// Top level of the event-stream parser: input register, parse state and result buffer.
// Bytes enter one per cycle while the input is ready. Each byte is parsed in a single
// registered step and gives zero, one or two tagged results; the result port delivers
// one result per cycle while the receiver is ready, so a byte that yields two results
// (a held CR released ahead of a value byte, or the LF of an id line with no colon, which
// gives id start and id accept together) holds back the next byte with results until the
// second is taken. Bytes pass through the input register, and results through the result
// buffer. Strings are not stored: value bytes stream out and downstream logic buffers them.
module sse_stream_parser (
    input  logic          clk,
    input  logic          rst_n,
    sse_byte_if.sink      byte_stream,
    sse_result_if.source  events
);
    import sse_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    push_t      step_push;
    push_t      obuf_push;
    logic       obuf_free;
    logic       step_fire;

    sse_step u_step (
        .state      (state_reg),
        .byte_in    (in_byte_reg),
        .state_next (state_next),
        .push       (step_push)
    );

    // bytes that produce nothing never wait on the result side
    assign step_fire = in_valid_reg && (obuf_free || !step_push.valid);
    assign byte_stream.ready = !in_valid_reg || step_fire;

    always_comb
    begin
        obuf_push       = step_push;
        obuf_push.valid = step_push.valid && step_fire;
    end

    sse_obuf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (obuf_push),
        .free   (obuf_free),
        .events (events)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                 <= 1'b0;
            state_reg.phase              <= PH_NAME;
            state_reg.name_count         <= 3'd0;
            state_reg.cands              <= 4'hF;
            state_reg.field_code         <= FLD_DATA;
            state_reg.value_start        <= 1'b1;
            state_reg.cr_held            <= 1'b0;
            state_reg.retry_accum        <= 32'd0;
            state_reg.retry_ok           <= 1'b1;
            state_reg.retry_digit_seen   <= 1'b0;
            state_reg.id_nul_seen        <= 1'b0;
            state_reg.data_seen          <= 1'b0;
            state_reg.retry_value        <= 32'd0;
            state_reg.retry_valid        <= 1'b0;
        end
        else
        begin
            if (byte_stream.ready)
                in_valid_reg <= byte_stream.valid;
            if (step_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
            in_byte_reg <= byte_stream.byte_in;
    end

endmodule
